FILE: rtl/core/allocation_event_checker_defines.svh
// ----------------------------------------------------------------------------
// allocation event checker assertion macros
// shared property forms used by the checker's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef ALLOCATION_EVENT_CHECKER_DEFINES_SVH
`define ALLOCATION_EVENT_CHECKER_DEFINES_SVH

// same-cycle implication
`define AEC_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AEC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/aec_pkg.sv
// ----------------------------------------------------------------------------
// aec_pkg
// types and constants shared by the allocation event checker modules
// ----------------------------------------------------------------------------
package aec_pkg;

   // table and field sizes
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int ADDR_BITS   = 48;
   localparam int SIZE_BITS   = 40;
   localparam int USED_BITS   = 48;
   localparam int TOTAL_BITS  = 63;
   localparam int LIVE_BITS   = 9;
   localparam int ERR_BITS    = 3;

   // error codes
   typedef enum logic [ERR_BITS-1:0] {
      ERR_NONE            = 3'd0,
      ERR_SIZE_MISMATCH   = 3'd1,
      ERR_UNKNOWN_FREE    = 3'd2,
      ERR_UNFREED_REALLOC = 3'd3,
      ERR_TABLE_FULL      = 3'd4
   } err_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic read;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/core/aec_ctrl.sv
// ----------------------------------------------------------------------------
// aec_ctrl
// sequencer for one event: capture, table scan, drain, decide and commit
// ----------------------------------------------------------------------------
module aec_ctrl import aec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      cmd.start  = 1'b0;
      cmd.read   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DECIDE: begin
            cmd.commit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/aec_datapath.sv
// ----------------------------------------------------------------------------
// aec_datapath
// entry memory, valid bits, scan match logic, totals and result register
// ----------------------------------------------------------------------------
module aec_datapath import aec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_is_free,
   input  logic [ADDR_BITS-1:0]  req_address,
   input  logic [SIZE_BITS-1:0]  req_block_size,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ERR_BITS-1:0]   rsp_error_code,
   output logic [USED_BITS-1:0]  rsp_bytes_in_use,
   output logic [TOTAL_BITS-1:0] rsp_total_allocated,
   output logic [LIVE_BITS-1:0]  rsp_live_count
);

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
   localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(TABLE_DEPTH - 1);

   // captured event
   logic                 req_free_ff;
   logic [ADDR_BITS-1:0] req_addr_ff;
   logic [SIZE_BITS-1:0] req_size_ff;

   // entry storage
   logic [ADDR_BITS-1:0]   entry_address_mem [TABLE_DEPTH];
   logic [SIZE_BITS-1:0]   entry_size_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   // scan pipeline
   logic [IDX_BITS-1:0]  scan_idx_ff;
   logic                 rd_vld_ff;
   logic                 rd_live_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff;
   logic [ADDR_BITS-1:0] rd_addr_ff;
   logic [SIZE_BITS-1:0] rd_size_ff;

   // scan findings
   logic                 hit_ff;
   logic [IDX_BITS-1:0]  hit_idx_ff;
   logic [SIZE_BITS-1:0] hit_size_ff;
   logic                 free_ff;
   logic [IDX_BITS-1:0]  free_idx_ff;

   // running totals
   logic [USED_BITS-1:0]  used_ff;
   logic [USED_BITS-1:0]  used_in;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] total_in;
   logic [LIVE_BITS-1:0]  live_ff;
   logic [LIVE_BITS-1:0]  live_in;

   // result register
   logic                  rsp_valid_ff;
   err_type               rsp_err_ff;
   logic [USED_BITS-1:0]  rsp_used_ff;
   logic [TOTAL_BITS-1:0] rsp_total_ff;
   logic [LIVE_BITS-1:0]  rsp_live_ff;

   // decision
   err_type           err_in;
   logic              do_insert;
   logic              do_release;
   logic [TOTAL_BITS:0] total_sum;
   logic [USED_BITS-1:0] size_ext;

   // capture event on accept
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_free_ff <= req_is_free;
         req_addr_ff <= req_address;
         req_size_ff <= req_block_size;
      end
   end

   // scan index
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         scan_idx_ff <= '0;
      end else if (cmd.read) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   // entry memory: insert write and scan read
   always_ff @(posedge clock) begin
      if (cmd.commit && do_insert) begin
         entry_address_mem[free_idx_ff] <= req_addr_ff;
         entry_size_mem[free_idx_ff]    <= req_size_ff;
      end
      if (cmd.read) begin
         rd_addr_ff <= entry_address_mem[scan_idx_ff];
         rd_size_ff <= entry_size_mem[scan_idx_ff];
      end
   end

   // valid bit and index alongside the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.read;
      end
      if (cmd.read) begin
         rd_live_ff <= valid_ff[scan_idx_ff];
         rd_idx_ff  <= scan_idx_ff;
      end
   end

   // first live match and lowest free slot
   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (rd_live_ff && !hit_ff && rd_addr_ff == req_addr_ff) begin
            hit_ff <= 1'b1;
         end
         if (!rd_live_ff && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
      if (rd_vld_ff && rd_live_ff && !hit_ff && rd_addr_ff == req_addr_ff) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_size_ff <= rd_size_ff;
      end
      if (rd_vld_ff && !rd_live_ff && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // event outcome
   always_comb begin
      err_in     = ERR_NONE;
      do_insert  = 1'b0;
      do_release = 1'b0;
      if (req_free_ff) begin
         if (!hit_ff) begin
            err_in = ERR_UNKNOWN_FREE;
         end else if (hit_size_ff != req_size_ff) begin
            err_in = ERR_SIZE_MISMATCH;
         end else begin
            do_release = 1'b1;
         end
      end else begin
         if (hit_ff) begin
            err_in = ERR_UNFREED_REALLOC;
         end else if (!free_ff) begin
            err_in = ERR_TABLE_FULL;
         end else begin
            do_insert = 1'b1;
         end
      end
   end

   // next totals: bytes in use wraps, total saturates
   always_comb begin
      size_ext  = USED_BITS'(req_size_ff);
      total_sum = {1'b0, total_ff} + (TOTAL_BITS + 1)'(req_size_ff);
      used_in   = used_ff;
      total_in  = total_ff;
      live_in   = live_ff;
      if (do_insert) begin
         used_in  = used_ff + size_ext;
         total_in = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
         live_in  = live_ff + 1'b1;
      end else if (do_release) begin
         used_in = used_ff - size_ext;
         live_in = live_ff - 1'b1;
      end
   end

   // table state update
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         total_ff <= '0;
         live_ff  <= '0;
      end else if (cmd.commit) begin
         if (do_insert) valid_ff[free_idx_ff] <= 1'b1;
         if (do_release) valid_ff[hit_idx_ff] <= 1'b0;
         used_ff  <= used_in;
         total_ff <= total_in;
         live_ff  <= live_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         rsp_err_ff   <= err_in;
         rsp_used_ff  <= used_in;
         rsp_total_ff <= total_in;
         rsp_live_ff  <= live_in;
      end
   end

   // status and outputs
   assign status.scan_last    = (scan_idx_ff == LAST_IDX);
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_error_code      = rsp_err_ff;
   assign rsp_bytes_in_use    = rsp_used_ff;
   assign rsp_total_allocated = rsp_total_ff;
   assign rsp_live_count      = rsp_live_ff;

endmodule

FILE: rtl/core/allocation_event_checker.sv
// ----------------------------------------------------------------------------
// allocation_event_checker
// checks allocation and release events against a table of live allocations
// ----------------------------------------------------------------------------
// One event is taken at a time and answers with one item carrying the error
// code and the bytes in use, saturating allocated total and live count after
// the event. The address is looked up by a scan of the whole entry memory
// through its single read port, one entry per cycle, then a drain state
// empties the read pipeline and a decide state commits. A new event is
// accepted on the cycle after the result is loaded, while that result may
// still wait on rsp_stall; a result still held there delays the commit of
// the next event. Valid bits sit in flip-flops cleared by reset, so no
// clearing pass follows reset. Errored events leave all state unchanged; a
// new entry goes into the lowest free slot.
`include "allocation_event_checker_defines.svh"

module allocation_event_checker import aec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_is_free,
   input  logic [ADDR_BITS-1:0]  req_address,
   input  logic [SIZE_BITS-1:0]  req_block_size,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ERR_BITS-1:0]   rsp_error_code,
   output logic [USED_BITS-1:0]  rsp_bytes_in_use,
   output logic [TOTAL_BITS-1:0] rsp_total_allocated,
   output logic [LIVE_BITS-1:0]  rsp_live_count
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   aec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table and totals
   aec_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_is_free         (req_is_free),
      .req_address         (req_address),
      .req_block_size      (req_block_size),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_error_code      (rsp_error_code),
      .rsp_bytes_in_use    (rsp_bytes_in_use),
      .rsp_total_allocated (rsp_total_allocated),
      .rsp_live_count      (rsp_live_count)
   );

   // commit only lands in a free result register
   `AEC_ASSERT_SAME(a_commit_out_free, clock, reset, cmd.commit, status.out_free, "commit with result register busy")

   // a commit always presents a result on the next cycle
   `AEC_ASSERT_NEXT(a_commit_rsp, clock, reset, cmd.commit, rsp_valid, "commit without result")

   // an accepted item holds off the next one while it is scanned
   `AEC_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall && !cmd.commit, "accept not followed by scan")

   // no scan read or commit happens in the cycle an item is captured
   `AEC_ASSERT_SAME(a_start_no_read, clock, reset, cmd.start, !cmd.read && !cmd.commit, "start overlaps scan or commit")

endmodule

FILE: tb/alloc_report_monitor.sv
// ----------------------------------------------------------------------------
// alloc_report_monitor
// watches both channels of the allocation event checker, keeps its own copy
// of the live allocation table, predicts the report item for every accepted
// event and compares each accepted report item with the oldest prediction
// ----------------------------------------------------------------------------
module alloc_report_monitor import aec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_is_free,
   input  logic [ADDR_BITS-1:0]  req_address,
   input  logic [SIZE_BITS-1:0]  req_block_size,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [ERR_BITS-1:0]   rsp_error_code,
   input  logic [USED_BITS-1:0]  rsp_bytes_in_use,
   input  logic [TOTAL_BITS-1:0] rsp_total_allocated,
   input  logic [LIVE_BITS-1:0]  rsp_live_count,
   output int                    mismatch_count,
   output int                    reports_due
);

   localparam logic [TOTAL_BITS-1:0] TOTAL_CAP = '1;

   typedef struct packed {
      err_type                code;
      logic [USED_BITS-1:0]  in_use;
      logic [TOTAL_BITS-1:0] total;
      logic [LIVE_BITS-1:0]  live;
   } alloc_report_type;

   // shadow of the allocation table and the running counters
   bit                    slot_live [TABLE_DEPTH];
   logic [ADDR_BITS-1:0]  slot_addr [TABLE_DEPTH];
   logic [SIZE_BITS-1:0]  slot_size [TABLE_DEPTH];
   logic [USED_BITS-1:0]  in_use_bytes;
   logic [TOTAL_BITS-1:0] alloc_sum;
   logic [LIVE_BITS-1:0]  live_slots;

   alloc_report_type pending_reports [$];
   int               errors_seen = 0;

   // apply one event to the shadow table and return the report it causes
   function automatic alloc_report_type apply_alloc_event(
      input logic                 release_ev,
      input logic [ADDR_BITS-1:0] addr,
      input logic [SIZE_BITS-1:0] size
   );
      int                  hit;
      int                  free_slot;
      logic [TOTAL_BITS:0] sum;
      alloc_report_type    rep;
      hit       = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (hit < 0 && slot_live[i] && slot_addr[i] == addr) hit = i;
         if (free_slot < 0 && !slot_live[i]) free_slot = i;
      end
      rep.code = ERR_NONE;
      if (release_ev) begin
         if (hit < 0) begin
            rep.code = ERR_UNKNOWN_FREE;
         end else if (slot_size[hit] != size) begin
            // entry stays when the size does not match
            rep.code = ERR_SIZE_MISMATCH;
         end else begin
            slot_live[hit] = 1'b0;
            live_slots     = live_slots - 1'b1;
            in_use_bytes   = in_use_bytes - USED_BITS'(size);
         end
      end else if (hit >= 0) begin
         // already live, reported even when the table is full
         rep.code = ERR_UNFREED_REALLOC;
      end else if (free_slot < 0) begin
         rep.code = ERR_TABLE_FULL;
      end else begin
         // lowest free slot takes the new entry
         slot_live[free_slot] = 1'b1;
         slot_addr[free_slot] = addr;
         slot_size[free_slot] = size;
         live_slots           = live_slots + 1'b1;
         in_use_bytes         = in_use_bytes + USED_BITS'(size);
         sum = {1'b0, alloc_sum} + (TOTAL_BITS + 1)'(size);
         alloc_sum = (sum > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : sum[TOTAL_BITS-1:0];
      end
      rep.in_use = in_use_bytes;
      rep.total  = alloc_sum;
      rep.live   = live_slots;
      return rep;
   endfunction

   // compare accepted reports first, then record the accepted event
   always @(posedge clock) begin
      alloc_report_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
         in_use_bytes = '0;
         alloc_sum    = '0;
         live_slots   = '0;
         pending_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("report item with no event waiting");
               errors_seen++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_error_code !== want.code) begin
                  $error("error_code: expected %0d, actual %0d", want.code, rsp_error_code);
                  errors_seen++;
               end
               if (rsp_bytes_in_use !== want.in_use) begin
                  $error("bytes_in_use: expected %0h, actual %0h",
                         want.in_use, rsp_bytes_in_use);
                  errors_seen++;
               end
               if (rsp_total_allocated !== want.total) begin
                  $error("total_allocated: expected %0h, actual %0h",
                         want.total, rsp_total_allocated);
                  errors_seen++;
               end
               if (rsp_live_count !== want.live) begin
                  $error("live_count: expected %0d, actual %0d", want.live, rsp_live_count);
                  errors_seen++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_reports.push_back(apply_alloc_event(req_is_free, req_address,
                                                        req_block_size));
      end
      mismatch_count <= errors_seen;
      reports_due    <= pending_reports.size();
   end

endmodule

FILE: tb/allocation_event_checker_tb.sv
// ----------------------------------------------------------------------------
// allocation_event_checker_tb
// drives allocation and release events into the checker with random gaps and
// report stalls: a short directed part, a fill of the whole table up to the
// full condition and back, then random bursts over a shared address pool
// ----------------------------------------------------------------------------
module allocation_event_checker_tb;
   import aec_pkg::*;

   localparam int POOL        = 288;
   localparam int BURSTS      = 14;
   localparam int BURST_ITEMS = 100;
   localparam int QUIET_FROM  = 12;
   localparam int HOLD_CYCLES = 1500;
   localparam int LATENCY     = TABLE_DEPTH + 40;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [ADDR_BITS-1:0] ADDR_ALL = '1;
   localparam logic [SIZE_BITS-1:0] SIZE_ALL = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_is_free = 1'b0;
   logic [ADDR_BITS-1:0]  req_address = '0;
   logic [SIZE_BITS-1:0]  req_block_size = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ERR_BITS-1:0]   rsp_error_code;
   logic [USED_BITS-1:0]  rsp_bytes_in_use;
   logic [TOTAL_BITS-1:0] rsp_total_allocated;
   logic [LIVE_BITS-1:0]  rsp_live_count;

   int mismatch_count;
   int reports_due;
   int cycle_count = 0;
   int phase = 0;
   bit quiet = 1'b0;

   logic [ADDR_BITS-1:0] pool_addr [POOL];
   logic [SIZE_BITS-1:0] pool_size [POOL];

   allocation_event_checker dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_is_free         (req_is_free),
      .req_address         (req_address),
      .req_block_size      (req_block_size),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_error_code      (rsp_error_code),
      .rsp_bytes_in_use    (rsp_bytes_in_use),
      .rsp_total_allocated (rsp_total_allocated),
      .rsp_live_count      (rsp_live_count)
   );

   alloc_report_monitor monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_is_free         (req_is_free),
      .req_address         (req_address),
      .req_block_size      (req_block_size),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_error_code      (rsp_error_code),
      .rsp_bytes_in_use    (rsp_bytes_in_use),
      .rsp_total_allocated (rsp_total_allocated),
      .rsp_live_count      (rsp_live_count),
      .mismatch_count      (mismatch_count),
      .reports_due         (reports_due)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // report side: one long hold-off in the first burst, short random stalls
   initial begin : report_side
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (!held && phase == 1) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // mix of sizes: wide, small, zero, all ones, medium
   function automatic logic [SIZE_BITS-1:0] pick_size();
      case ($urandom_range(0, 5))
         0:       return SIZE_BITS'({$urandom, $urandom});
         1:       return SIZE_BITS'($urandom_range(0, 255));
         2:       return '0;
         3:       return SIZE_ALL;
         default: return SIZE_BITS'($urandom_range(0, 1 << 20));
      endcase
   endfunction

   // offer one event and hold it until accepted, then maybe leave a gap
   task automatic offer_event(input logic release_ev, input logic [ADDR_BITS-1:0] addr,
                              input logic [SIZE_BITS-1:0] size);
      req_valid      <= 1'b1;
      req_is_free    <= release_ev;
      req_address    <= addr;
      req_block_size <= size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // stop offering until every outstanding report has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_due != 0);
   endtask

   // one random event over the pool, biased toward allocation by alloc_pct
   task automatic random_event(input int alloc_pct);
      int   idx;
      logic release_ev;
      idx        = $urandom_range(0, POOL - 1);
      release_ev = ($urandom_range(0, 99) >= alloc_pct);
      if ($urandom_range(0, 99) < 4)
         offer_event(release_ev, ADDR_BITS'({$urandom, $urandom}), pick_size());
      else if (release_ev && $urandom_range(0, 99) < 12)
         offer_event(1'b1, pool_addr[idx], pick_size());
      else
         offer_event(release_ev, pool_addr[idx], pool_size[idx]);
   endtask

   initial begin : event_side
      int alloc_pct;
      // distinct pool addresses: low bits carry the index
      for (int i = 0; i < POOL; i++) begin
         pool_addr[i] = {(ADDR_BITS - 9)'({$urandom, $urandom}), 9'(i)};
         pool_size[i] = pick_size();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every error but table full, release and reuse of slots
      offer_event(1'b0, '0, '0);
      offer_event(1'b0, ADDR_ALL, SIZE_ALL);
      offer_event(1'b0, ADDR_ALL, 40'd5);
      offer_event(1'b1, ADDR_ALL, SIZE_ALL - 1'b1);
      offer_event(1'b1, 48'h1234_5678_9abc, 40'd7);
      offer_event(1'b1, ADDR_ALL, SIZE_ALL);
      offer_event(1'b1, '0, '0);
      offer_event(1'b1, '0, '0);
      offer_event(1'b0, 48'h5555_5555_5555, 40'haa_aaaa_aaaa);
      offer_event(1'b0, 48'haaaa_aaaa_aaaa, 40'h55_5555_5555);
      offer_event(1'b1, 48'h5555_5555_5555, 40'h55_5555_5555);
      offer_event(1'b1, 48'h5555_5555_5555, 40'haa_aaaa_aaaa);
      offer_event(1'b0, 48'h10, 40'd1);
      offer_event(1'b0, 48'h20, 40'd2);
      offer_event(1'b0, 48'h30, 40'd3);
      offer_event(1'b1, 48'h10, 40'd1);
      offer_event(1'b0, 48'h40, 40'd4);
      offer_event(1'b1, 48'h40, 40'd4);
      offer_event(1'b1, 48'h20, 40'd2);
      offer_event(1'b1, 48'h30, 40'd3);
      offer_event(1'b1, 48'haaaa_aaaa_aaaa, 40'h55_5555_5555);

      // fill the whole table, hit the full case, then release everything
      for (int i = 0; i < TABLE_DEPTH; i++) offer_event(1'b0, pool_addr[i], pool_size[i]);
      offer_event(1'b0, pool_addr[$urandom_range(TABLE_DEPTH, POOL - 1)], pick_size());
      offer_event(1'b0, pool_addr[$urandom_range(0, TABLE_DEPTH - 1)], pick_size());
      offer_event(1'b1, pool_addr[7], pool_size[7] + 1'b1);
      for (int i = 0; i < TABLE_DEPTH; i++) offer_event(1'b1, pool_addr[i], pool_size[i]);
      wait_drained();

      // random bursts: allocation heavy, mixed, release heavy
      for (int b = 0; b < BURSTS; b++) begin
         phase = b + 1;
         quiet = (b >= QUIET_FROM);
         case (b % 6)
            0, 1, 2: alloc_pct = 90;
            3:       alloc_pct = 50;
            default: alloc_pct = 15;
         endcase
         repeat (BURST_ITEMS) random_event(alloc_pct);
      end

      // drain and settle
      wait_drained();
      repeat (LATENCY) @(posedge clock);
      if (mismatch_count == 0 && reports_due == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
